// ===== hw/rtl/sha1_pkg.sv =====
// Package for the SHA-1 digest block: constants, state codes and control structs.
package sha1_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumRnd  = 80;
  localparam int unsigned RndW    = 7;
  localparam int unsigned CntW    = 61;
  localparam logic [7:0]  PadByte = 8'h80;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BYTE, ST_INIT, ST_RND, ST_ADD, ST_PAD, ST_CLR, ST_LEN, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_DATA, PH_PADX, PH_FINAL
  } phase_t;

  typedef struct packed {
    logic load_item;
    logic put_byte;
    logic init_vars;
    logic round;
    logic add_chain;
    logic pad;
    logic clr;
    logic len;
    logic out_adv;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic wrap;
    logic last;
    logic n_ge56;
    logic round_last;
    logic out_last;
  } sts_t;

endpackage

// ===== hw/rtl/sha1_message_digest.sv =====
// Top level: SHA-1 digest over a byte stream delivered as 32-bit words.
// An item is accepted, then its valid bytes (up to four) are packed into the block one at a time.
// Each filled 64-byte block is compressed: load, 80 rounds in one round unit, chain add.
// A last item adds pad and length, one or two compressions, then
// five digest words, one per cycle unless stalled; the next item is taken after.
// Synchronous active-low reset restores the initial hash values and clears counts.
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha1_pkg::cmd_t cmd;
  sha1_pkg::sts_t sts;

  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sha1_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_data_word    (in_data_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_is_last      (in_is_last),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

// ===== hw/rtl/sha1_datapath.sv =====
// Datapath: byte packing, message schedule shift line, round unit, chaining words.
module sha1_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  sha1_pkg::cmd_t     cmd,
  output sha1_pkg::sts_t     sts,
  input  logic [31:0]        in_data_word,
  input  logic [2:0]         in_valid_bytes,
  input  logic               in_is_last,
  output logic [31:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word
);

  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] h_r [5];
  logic [31:0] v_r [5];
  logic [31:0] item_r;
  logic [2:0]  cnt_r;
  logic        last_r;
  logic [5:0]  bic_r;
  logic [sha1_pkg::CntW-1:0] msg_r;
  logic [sha1_pkg::RndW-1:0] rnd_r;
  logic [2:0]  oidx_r;

  logic [31:0] wt, f, k, tmp, sch;
  logic [63:0] bits;
  logic [3:0]  widx;
  logic [1:0]  lane;

  assign widx = bic_r[5:2];
  assign lane = bic_r[1:0];
  assign bits = {msg_r, 3'b000};

  assign sch = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign wt  = (rnd_r < sha1_pkg::RndW'(16)) ? w_r[0] : {sch[30:0], sch[31]};

  always_comb begin
    if (rnd_r < sha1_pkg::RndW'(20)) begin
      f = (v_r[1] & v_r[2]) | (~v_r[1] & v_r[3]);
      k = sha1_pkg::K0;
    end else if (rnd_r < sha1_pkg::RndW'(40)) begin
      f = v_r[1] ^ v_r[2] ^ v_r[3];
      k = sha1_pkg::K1;
    end else if (rnd_r < sha1_pkg::RndW'(60)) begin
      f = (v_r[1] & v_r[2]) | (v_r[1] & v_r[3]) | (v_r[2] & v_r[3]);
      k = sha1_pkg::K2;
    end else begin
      f = v_r[1] ^ v_r[2] ^ v_r[3];
      k = sha1_pkg::K3;
    end
  end

  assign tmp = {v_r[0][26:0], v_r[0][31:27]} + f + v_r[4] + k + wt;

  // block word updates: byte insert, pad, clear, length, schedule shift
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      w_nxt[j] = w_r[j];
      if (cmd.put_byte && widx == 4'(j)) begin
        for (int b = 0; b < 4; b++) begin
          if (lane == 2'(b)) w_nxt[j][31-8*b -: 8] = item_r[31:24];
        end
      end
      if (cmd.pad) begin
        if (4'(j) > widx) begin
          w_nxt[j] = '0;
        end else if (4'(j) == widx) begin
          for (int b = 0; b < 4; b++) begin
            if (2'(b) == lane) w_nxt[j][31-8*b -: 8] = sha1_pkg::PadByte;
            else if (2'(b) > lane) w_nxt[j][31-8*b -: 8] = 8'h00;
          end
        end
      end
      if (cmd.clr) w_nxt[j] = '0;
      if (cmd.round) w_nxt[j] = (j == 15) ? wt : w_r[(j + 1) % 16];
    end
    if (cmd.len) begin
      w_nxt[14] = bits[63:32];
      w_nxt[15] = bits[31:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 16; j++) w_r[j] <= w_nxt[j];
    if (cmd.load_item) begin
      item_r <= in_data_word;
      cnt_r  <= (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
      last_r <= in_is_last;
    end else if (cmd.put_byte) begin
      item_r <= {item_r[23:0], 8'h00};
      cnt_r  <= cnt_r - 3'd1;
    end
    if (cmd.init_vars) begin
      for (int j = 0; j < 5; j++) v_r[j] <= h_r[j];
    end else if (cmd.round) begin
      v_r[0] <= tmp;
      v_r[1] <= v_r[0];
      v_r[2] <= {v_r[1][1:0], v_r[1][31:2]};
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r[0] <= sha1_pkg::H0;
      h_r[1] <= sha1_pkg::H1;
      h_r[2] <= sha1_pkg::H2;
      h_r[3] <= sha1_pkg::H3;
      h_r[4] <= sha1_pkg::H4;
      bic_r  <= '0;
      msg_r  <= '0;
      rnd_r  <= '0;
      oidx_r <= '0;
    end else begin
      if (cmd.put_byte) begin
        bic_r <= bic_r + 6'd1;
        msg_r <= msg_r + sha1_pkg::CntW'(1);
      end
      if (cmd.init_vars) rnd_r <= '0;
      else if (cmd.round) rnd_r <= rnd_r + sha1_pkg::RndW'(1);
      if (cmd.add_chain) begin
        for (int j = 0; j < 5; j++) h_r[j] <= h_r[j] + v_r[j];
      end
      if (cmd.out_adv) begin
        if (oidx_r == 3'd4) begin
          // message done: restart chaining and counts
          oidx_r <= '0;
          bic_r  <= '0;
          msg_r  <= '0;
          h_r[0] <= sha1_pkg::H0;
          h_r[1] <= sha1_pkg::H1;
          h_r[2] <= sha1_pkg::H2;
          h_r[3] <= sha1_pkg::H3;
          h_r[4] <= sha1_pkg::H4;
        end else begin
          oidx_r <= oidx_r + 3'd1;
        end
      end
    end
  end

  always_comb begin
    sts.cnt_zero   = (cnt_r == 3'd0);
    sts.cnt_one    = (cnt_r == 3'd1);
    sts.wrap       = (bic_r == 6'd63);
    sts.last       = last_r;
    sts.n_ge56     = (bic_r[5:3] == 3'b111);
    sts.round_last = (rnd_r == sha1_pkg::RndW'(sha1_pkg::NumRnd - 1));
    sts.out_last   = (oidx_r == 3'd4);
  end

  always_comb begin
    out_digest_word = h_r[0];
    case (oidx_r)
      3'd1:    out_digest_word = h_r[1];
      3'd2:    out_digest_word = h_r[2];
      3'd3:    out_digest_word = h_r[3];
      3'd4:    out_digest_word = h_r[4];
      default: out_digest_word = h_r[0];
    endcase
  end

  assign out_word_index = oidx_r;
  assign out_last_word  = (oidx_r == 3'd4);

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= sha1_pkg::RndW'(sha1_pkg::NumRnd))
    else $error("round counter out of range");
  a_oidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    oidx_r <= 3'd4)
    else $error("digest index out of range");
  a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put_byte && sts.wrap |=> bic_r == 6'd0)
    else $error("byte position did not wrap");

endmodule

// ===== hw/rtl/sha1_ctrl.sv =====
// Controller: sequences byte packing, padding, compression and digest output.
module sha1_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  sha1_pkg::sts_t  sts,
  output sha1_pkg::cmd_t  cmd
);

  sha1_pkg::state_t state_r, state_nxt;
  sha1_pkg::phase_t phase_r, phase_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sha1_pkg::ST_BYTE;
      end
      sha1_pkg::ST_BYTE: begin
        if (sts.cnt_zero) begin
          state_nxt = sts.last ? sha1_pkg::ST_PAD : sha1_pkg::ST_IDLE;
        end else if (sts.wrap) begin
          state_nxt = sha1_pkg::ST_INIT;
          phase_nxt = sha1_pkg::PH_DATA;
        end else if (sts.cnt_one) begin
          state_nxt = sts.last ? sha1_pkg::ST_PAD : sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_INIT: state_nxt = sha1_pkg::ST_RND;
      sha1_pkg::ST_RND: begin
        if (sts.round_last) state_nxt = sha1_pkg::ST_ADD;
      end
      sha1_pkg::ST_ADD: begin
        case (phase_r)
          sha1_pkg::PH_FINAL: state_nxt = sha1_pkg::ST_OUT;
          sha1_pkg::PH_PADX:  state_nxt = sha1_pkg::ST_CLR;
          default: begin
            if (!sts.cnt_zero) state_nxt = sha1_pkg::ST_BYTE;
            else state_nxt = sts.last ? sha1_pkg::ST_PAD : sha1_pkg::ST_IDLE;
          end
        endcase
      end
      sha1_pkg::ST_PAD: begin
        if (sts.n_ge56) begin
          state_nxt = sha1_pkg::ST_INIT;
          phase_nxt = sha1_pkg::PH_PADX;
        end else begin
          state_nxt = sha1_pkg::ST_LEN;
        end
      end
      sha1_pkg::ST_CLR: state_nxt = sha1_pkg::ST_LEN;
      sha1_pkg::ST_LEN: begin
        state_nxt = sha1_pkg::ST_INIT;
        phase_nxt = sha1_pkg::PH_FINAL;
      end
      sha1_pkg::ST_OUT: begin
        if (!out_stall && sts.out_last) begin
          state_nxt = sha1_pkg::ST_IDLE;
          phase_nxt = sha1_pkg::PH_DATA;
        end
      end
      default: state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load_item = (state_r == sha1_pkg::ST_IDLE) && in_valid;
    cmd.put_byte  = (state_r == sha1_pkg::ST_BYTE) && !sts.cnt_zero;
    cmd.init_vars = (state_r == sha1_pkg::ST_INIT);
    cmd.round     = (state_r == sha1_pkg::ST_RND);
    cmd.add_chain = (state_r == sha1_pkg::ST_ADD);
    cmd.pad       = (state_r == sha1_pkg::ST_PAD);
    cmd.clr       = (state_r == sha1_pkg::ST_CLR);
    cmd.len       = (state_r == sha1_pkg::ST_LEN);
    cmd.out_adv   = (state_r == sha1_pkg::ST_OUT) && !out_stall;
  end

  assign in_stall  = (state_r != sha1_pkg::ST_IDLE);
  assign out_valid = (state_r == sha1_pkg::ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1_pkg::ST_IDLE;
      phase_r <= sha1_pkg::PH_DATA;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  a_accept_byte: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha1_pkg::ST_IDLE && in_valid |=> state_r == sha1_pkg::ST_BYTE)
    else $error("accepted item not unpacked");
  a_rnd_add: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha1_pkg::ST_RND && sts.round_last |=> state_r == sha1_pkg::ST_ADD)
    else $error("rounds did not end in chain add");
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_adv && sts.out_last |=> state_r == sha1_pkg::ST_IDLE)
    else $error("digest output did not finish");

endmodule

// ===== test/tb.sv =====
// Testbench for the SHA-1 message digest block: directed and random messages, scoreboarded.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_data_word;
  logic [2:0]  in_valid_bytes;
  logic        in_is_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  localparam logic [31:0] InitChain [5] = '{
    sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3, sha1_pkg::H4
  };

  digest_item_t digest_queue[$];
  logic [31:0]  hash_state [5];
  logic [31:0]  msg_block [16];
  int unsigned  block_fill;
  logic [60:0]  msg_len;
  int unsigned  fail_cnt;
  longint unsigned cycle_cnt;
  bit           idle_on;

  sha1_message_digest u_top (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 64'd2_000_000) begin
      $display("FAIL sha1_message_digest");
      $finish;
    end
  end

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wt, t2;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
    d = hash_state[3]; e = hash_state[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = rotl(w[(t + 13) & 15] ^ w[(t + 8) & 15] ^ w[(t + 2) & 15] ^ w[t & 15], 1);
        w[t & 15] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d); k = sha1_pkg::K0;
      end else if (t < 40) begin
        f = b ^ c ^ d; k = sha1_pkg::K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d; k = sha1_pkg::K3;
      end
      t2 = rotl(a, 5) + f + e + k + wt;
      e = d; d = c; c = rotl(b, 30); b = a; a = t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
    hash_state[3] += d; hash_state[4] += e;
  endtask

  task automatic store_byte(int unsigned pos, logic [7:0] val);
    msg_block[pos >> 2][24 - 8 * (pos & 3) +: 8] = val;
  endtask

  task automatic hash_reset();
    for (int i = 0; i < 5; i++) hash_state[i] = InitChain[i];
    block_fill = 0;
    msg_len = '0;
  endtask

  // Advance the digest model by one accepted item and queue any digest words.
  task automatic predict_digest(logic [31:0] data, logic [2:0] nbytes, logic last);
    int unsigned cnt;
    logic [63:0] bits;
    cnt = (nbytes > 4) ? 4 : nbytes;
    for (int i = 0; i < cnt; i++) begin
      store_byte(block_fill, data[31 - 8 * i -: 8]);
      block_fill = (block_fill + 1) & 63;
      msg_len = msg_len + 1;
      if (block_fill == 0) compress();
    end
    if (last) begin
      bits = {msg_len, 3'b000};
      store_byte(block_fill, sha1_pkg::PadByte);
      for (int p = block_fill + 1; p < 64; p++) store_byte(p, 8'h00);
      if (block_fill >= 56) begin
        compress();
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
      end
      msg_block[14] = bits[63:32];
      msg_block[15] = bits[31:0];
      compress();
      for (int i = 0; i < 5; i++)
        digest_queue.push_back('{hash_state[i], 3'(i), i == 4});
      hash_reset();
    end
  endtask

  // Drive one item; hold until accepted, then drop valid.
  task automatic send_item(logic [31:0] data, logic [2:0] nbytes, logic last);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 32) @(negedge clk);
    in_valid       <= 1'b1;
    in_data_word   <= data;
    in_valid_bytes <= nbytes;
    in_is_last     <= last;
    do @(posedge clk); while (in_stall);
    predict_digest(data, nbytes, last);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_message(int unsigned nbytes);
    int unsigned left;
    left = nbytes;
    while (left > 4) begin
      send_item($urandom, 3'd4, 1'b0);
      left -= 4;
    end
    send_item($urandom, 3'(left), 1'b1);
  endtask

  task automatic drain();
    while (digest_queue.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic test_boundaries();
    send_item(32'h0, 3'd0, 1'b1);               // empty message
    send_item(32'hFFFFFFFF, 3'd7, 1'b1);        // count above four
    send_item(32'h61626300, 3'd3, 1'b1);        // "abc"
    send_item(32'hAAAAAAAA, 3'd1, 1'b0);        // short word, not last
    send_item(32'h55555555, 3'd5, 1'b0);
    send_item(32'h12345678, 3'd2, 1'b1);
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
    send_item(32'h0, 3'd6, 1'b0);
    send_item(32'hDEADBEEF, 3'd0, 1'b1);
  endtask

  task automatic test_pause();
    drain();
    send_message(3);
    drain();
  endtask

  task automatic test_random();
    int unsigned sent;
    sent = 0;
    while (sent < 330) begin
      if ($urandom_range(9) < 7) begin
        int unsigned len;
        len = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(70);
        send_message(len);
        sent += len / 4 + 1;
      end else begin
        int unsigned n;
        n = $urandom_range(6);
        for (int i = 0; i < n; i++)
          send_item($urandom, 3'($urandom_range(7)), 1'b0);
        send_item($urandom, 3'($urandom_range(7)), 1'b1);
        sent += n + 1;
      end
      idle_on = (sent < 120 || sent > 220);
    end
  endtask

  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 32);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        $error("unexpected digest word %h", out_digest_word);
        fail_cnt++;
      end else begin
        digest_item_t exp;
        exp = digest_queue.pop_front();
        if (out_digest_word !== exp.word) begin
          $error("digest_word exp %h got %h", exp.word, out_digest_word);
          fail_cnt++;
        end
        if (out_word_index !== exp.index) begin
          $error("word_index exp %0d got %0d", exp.index, out_word_index);
          fail_cnt++;
        end
        if (out_last_word !== exp.last) begin
          $error("last_word exp %0d got %0d", exp.last, out_last_word);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_word = '0;
    in_valid_bytes = '0;
    in_is_last = 1'b0;
    out_stall = 1'b0;
    fail_cnt = 0;
    cycle_cnt = 0;
    idle_on = 1'b1;
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    hash_reset();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_boundaries();
    test_pause();
    test_random();
    drain();
    if (fail_cnt == 0 && digest_queue.size() == 0) begin
      $display("PASS sha1_message_digest");
    end else begin
      $display("FAIL sha1_message_digest");
    end
    $finish;
  end
endmodule
